/* sv/quaternion_to_rotation_matrix_defines.svh */
// Assertion macros for the quaternion to rotation matrix block.
// Used by the top level; needs clk and arst_n in the including scope.
`ifndef QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH
`define QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH

// Consequent must hold whenever the antecedent holds, outside reset.
`define QRM_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qrm implication failed");

// Expression must hold at every edge outside reset.
`define QRM_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("qrm invariant failed");

`endif

/* sv/qrm_pkg.sv */
// Shared constants and transaction types for the quaternion to rotation matrix block.
// No dependencies.
`default_nettype none
package qrm_pkg;
	localparam int IN_WIDTH      = 16;
	localparam int OUT_FRAC_BITS = 14;
	localparam int OUT_WIDTH     = OUT_FRAC_BITS + 2;
	localparam int WORK_BITS     = 31;

	typedef struct packed {
		logic signed [IN_WIDTH-1:0] quat_x;
		logic signed [IN_WIDTH-1:0] quat_y;
		logic signed [IN_WIDTH-1:0] quat_z;
		logic signed [IN_WIDTH-1:0] quat_w;
	} quat_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] elem_0;
		logic signed [OUT_WIDTH-1:0] elem_1;
		logic signed [OUT_WIDTH-1:0] elem_2;
		logic signed [OUT_WIDTH-1:0] elem_4;
		logic signed [OUT_WIDTH-1:0] elem_5;
		logic signed [OUT_WIDTH-1:0] elem_6;
		logic signed [OUT_WIDTH-1:0] elem_8;
		logic signed [OUT_WIDTH-1:0] elem_9;
		logic signed [OUT_WIDTH-1:0] elem_10;
	} elems_t;
endpackage
`default_nettype wire

/* sv/qrm_front.sv */
// Front end: products, sum of squares and matrix numerators, then sign and magnitude.
// Three pipeline stages; uses qrm_pkg.
`default_nettype none
module qrm_front #(
	parameter int W = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                vld_in,
	input  wire logic signed [W-1:0] comp [4],
	output logic                     vld_out,
	output logic                     zero_out,
	output logic [2*W:0]             mag_out [9],
	output logic                     neg_out [9],
	output logic [2*W:0]             n_out
);
	import qrm_pkg::*;

	localparam int PW = 2 * W;
	localparam int NW = 2 * W + 3;
	localparam int MW = 2 * W + 1;

	// Product order: xx yy zz ww xy xz yz wx wy wz.
	logic signed [PW-1:0] prod_s2 [10];
	logic                 vld_s2;
	logic signed [NW-1:0] nn_s3;
	logic signed [NW-1:0] num_s3 [9];
	logic                 vld_s3;
	logic                 vld_s4;
	logic                 zero_s4;
	logic [MW-1:0]        mag_s4 [9];
	logic                 neg_s4 [9];
	logic [MW-1:0]        n_s4;

	logic signed [NW-1:0] e [10];
	logic signed [NW-1:0] nn_c;
	logic signed [NW-1:0] num_c [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s2 <= vld_in;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2[0] <= comp[0] * comp[0];
		prod_s2[1] <= comp[1] * comp[1];
		prod_s2[2] <= comp[2] * comp[2];
		prod_s2[3] <= comp[3] * comp[3];
		prod_s2[4] <= comp[0] * comp[1];
		prod_s2[5] <= comp[0] * comp[2];
		prod_s2[6] <= comp[1] * comp[2];
		prod_s2[7] <= comp[3] * comp[0];
		prod_s2[8] <= comp[3] * comp[1];
		prod_s2[9] <= comp[3] * comp[2];
	end

	always_comb begin
		for (int i = 0; i < 10; i++) e[i] = NW'(prod_s2[i]);
		nn_c     = e[0] + e[1] + e[2] + e[3];
		num_c[0] = nn_c - ((e[1] + e[2]) <<< 1);
		num_c[1] = (e[4] + e[9]) <<< 1;
		num_c[2] = (e[5] - e[8]) <<< 1;
		num_c[3] = (e[4] - e[9]) <<< 1;
		num_c[4] = nn_c - ((e[0] + e[2]) <<< 1);
		num_c[5] = (e[6] + e[7]) <<< 1;
		num_c[6] = (e[5] + e[8]) <<< 1;
		num_c[7] = (e[6] - e[7]) <<< 1;
		num_c[8] = nn_c - ((e[0] + e[1]) <<< 1);
	end

	always_ff @(posedge clk) begin
		nn_s3 <= nn_c;
		for (int i = 0; i < 9; i++) num_s3[i] <= num_c[i];
	end

	// Every numerator is bounded by the squared length, so the magnitude fits MW bits.
	always_ff @(posedge clk) begin
		zero_s4 <= (nn_s3 == '0);
		n_s4    <= nn_s3[MW-1:0];
		for (int i = 0; i < 9; i++) begin
			neg_s4[i] <= num_s3[i][NW-1];
			mag_s4[i] <= num_s3[i][NW-1] ? MW'(-num_s3[i]) : num_s3[i][MW-1:0];
		end
	end

	assign vld_out  = vld_s4;
	assign zero_out = zero_s4;
	assign mag_out  = mag_s4;
	assign neg_out  = neg_s4;
	assign n_out    = n_s4;
endmodule
`default_nettype wire

/* sv/qrm_div_lane.sv */
// One element's pipelined restoring divider: quotient bit per stage, then rounding.
// Uses qrm_pkg.
`default_nettype none
module qrm_div_lane #(
	parameter int MW = 33,
	parameter int F  = 14
) (
	input  wire logic          clk,
	input  wire logic [MW-1:0] mag,
	input  wire logic [MW-1:0] n,
	input  wire logic          neg,
	output logic signed [F+1:0] elem
);
	import qrm_pkg::*;

	localparam int OW = F + 2;

	logic [MW-1:0] rem_s [F+1];
	logic [F:0]    quo_s [F+1];
	logic [MW-1:0] n_s   [F+1];
	logic          neg_s [F+1];
	logic signed [OW-1:0] elem_s;

	// Integer bit: the magnitude never exceeds the divisor.
	always_ff @(posedge clk) begin
		rem_s[0] <= (mag >= n) ? mag - n : mag;
		quo_s[0] <= (F+1)'(mag >= n);
		n_s[0]   <= n;
		neg_s[0] <= neg;
	end

	for (genvar k = 1; k <= F; k++) begin : g_step
		logic [MW:0] r2;
		logic [MW:0] diff;
		logic        ge;
		always_comb begin
			r2   = {rem_s[k-1], 1'b0};
			ge   = r2 >= {1'b0, n_s[k-1]};
			diff = r2 - {1'b0, n_s[k-1]};
		end
		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? diff[MW-1:0] : r2[MW-1:0];
			quo_s[k] <= {quo_s[k-1][F-1:0], ge};
			n_s[k]   <= n_s[k-1];
			neg_s[k] <= neg_s[k-1];
		end
	end

	logic          rnd;
	logic [OW-1:0] qr;
	logic [OW-1:0] qc;
	always_comb begin
		rnd = {rem_s[F], 1'b0} >= {1'b0, n_s[F]};
		qr  = {1'b0, quo_s[F]} + OW'(rnd);
		qc  = (qr > (OW'(1) << F)) ? (OW'(1) << F) : qr;
	end

	always_ff @(posedge clk) begin
		elem_s <= neg_s[F] ? -$signed(qc) : $signed(qc);
	end

	assign elem = elem_s;
endmodule
`default_nettype wire

/* sv/quaternion_to_rotation_matrix.sv */
// Quaternion to rotation matrix: ports, input and output registers, zero-length override.
// Uses qrm_pkg, qrm_front, qrm_div_lane and the assertion macro header.
//
// Accepts one quaternion in every cycle (busy is never raised) and gives its nine
// matrix elements in input order, marked by a one-cycle done strobe. Each passes
// through one input stage, three front-end stages of products, sums and sign and
// magnitude, the divider lanes, which resolve one quotient bit per pipeline stage,
// and the output register. Results cannot be held off by the receiver.
`default_nettype none
`include "quaternion_to_rotation_matrix_defines.svh"
module quaternion_to_rotation_matrix (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire qrm_pkg::quat_t quat,
	output logic               done,
	output qrm_pkg::elems_t    elems
);
	import qrm_pkg::*;

	localparam int W   = (IN_WIDTH > WORK_BITS) ? WORK_BITS : IN_WIDTH;
	localparam int SH  = IN_WIDTH - W;
	localparam int MW  = 2 * W + 1;
	localparam int F   = OUT_FRAC_BITS;
	localparam int OW  = F + 2;
	localparam int DL  = F + 2;
	localparam int TOT = DL + 5;

	logic signed [W-1:0] comp_s1 [4];
	logic                vld_s1;
	logic                vld_f;
	logic                zero_f;
	logic [MW-1:0]       mag_f [9];
	logic                neg_f [9];
	logic [MW-1:0]       n_f;
	logic signed [OW-1:0] lane_elem [9];
	logic                vld_dly_q  [DL];
	logic                zero_dly_q [DL];
	logic                done_q;
	elems_t              elems_q;

	assign busy = 1'b0;

	// Components wider than the working width are floored down to it.
	always_ff @(posedge clk) begin
		comp_s1[0] <= W'(quat.quat_x >>> SH);
		comp_s1[1] <= W'(quat.quat_y >>> SH);
		comp_s1[2] <= W'(quat.quat_z >>> SH);
		comp_s1[3] <= W'(quat.quat_w >>> SH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	qrm_front #(.W(W)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_in   (vld_s1),
		.comp     (comp_s1),
		.vld_out  (vld_f),
		.zero_out (zero_f),
		.mag_out  (mag_f),
		.neg_out  (neg_f),
		.n_out    (n_f)
	);

	for (genvar i = 0; i < 9; i++) begin : g_lane
		qrm_div_lane #(.MW(MW), .F(F)) u_lane (
			.clk  (clk),
			.mag  (mag_f[i]),
			.n    (n_f),
			.neg  (neg_f[i]),
			.elem (lane_elem[i])
		);
	end

	// Valid and zero flags run alongside the divider lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DL; k++) vld_dly_q[k] <= 1'b0;
		end else begin
			vld_dly_q[0] <= vld_f;
			for (int k = 1; k < DL; k++) vld_dly_q[k] <= vld_dly_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		zero_dly_q[0] <= zero_f;
		for (int k = 1; k < DL; k++) zero_dly_q[k] <= zero_dly_q[k-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_dly_q[DL-1];
		end
	end

	logic signed [OW-1:0] one_c;
	logic signed [OW-1:0] diag_c [3];
	logic signed [OW-1:0] off_c  [6];
	always_comb begin
		one_c = OW'(1) << F;
		diag_c[0] = zero_dly_q[DL-1] ? one_c : lane_elem[0];
		diag_c[1] = zero_dly_q[DL-1] ? one_c : lane_elem[4];
		diag_c[2] = zero_dly_q[DL-1] ? one_c : lane_elem[8];
		off_c[0]  = zero_dly_q[DL-1] ? '0 : lane_elem[1];
		off_c[1]  = zero_dly_q[DL-1] ? '0 : lane_elem[2];
		off_c[2]  = zero_dly_q[DL-1] ? '0 : lane_elem[3];
		off_c[3]  = zero_dly_q[DL-1] ? '0 : lane_elem[5];
		off_c[4]  = zero_dly_q[DL-1] ? '0 : lane_elem[6];
		off_c[5]  = zero_dly_q[DL-1] ? '0 : lane_elem[7];
	end

	always_ff @(posedge clk) begin
		elems_q.elem_0  <= diag_c[0];
		elems_q.elem_1  <= off_c[0];
		elems_q.elem_2  <= off_c[1];
		elems_q.elem_4  <= off_c[2];
		elems_q.elem_5  <= diag_c[1];
		elems_q.elem_6  <= off_c[3];
		elems_q.elem_8  <= off_c[4];
		elems_q.elem_9  <= off_c[5];
		elems_q.elem_10 <= diag_c[2];
	end

	assign done  = done_q;
	assign elems = elems_q;

	`QRM_ASSERT_IMPLIES(a_done_follows_start, done, $past(start, TOT))
	`QRM_ASSERT_IMPLIES(a_zero_gives_identity, done && $past(quat == '0, TOT), elems.elem_0 == one_c && elems.elem_1 == '0 && elems.elem_10 == one_c)
	`QRM_ASSERT_IMPLIES(a_diag_in_range, done, elems.elem_5 <= one_c && elems.elem_5 >= -one_c)
endmodule
`default_nettype wire

/* dv/tb.sv */
// Self-checking bench for the quaternion to rotation matrix block.
// Depends on qrm_pkg and quaternion_to_rotation_matrix; predicts each matrix in fixed point.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import qrm_pkg::*;

	localparam int LATENCY = OUT_FRAC_BITS + 7;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	quat_t quat;
	logic done;
	elems_t elems;

	quat_t pending_quats[$];
	elems_t expected_mats[$];
	int errors = 0;
	bit stim_done = 0;
	bit calm = 0;
	bit hold_for_drain = 0;
	bit drain_seen = 0;
	int gap_left = 0;

	quaternion_to_rotation_matrix u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.quat(quat), .done(done), .elems(elems)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Element value num/n in Q1.OUT_FRAC_BITS, rounded half away from zero, clamped.
	function automatic logic signed [OUT_WIDTH-1:0] scaled_ratio(longint num, longint n);
		longint mag;
		longint q;
		longint r;
		bit neg;
		neg = num < 0;
		mag = neg ? -num : num;
		q = mag / n;
		r = mag % n;
		if (q > 1)
			q = 2;
		for (int i = 0; i < OUT_FRAC_BITS; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= n) begin
				r = r - n;
				q = q | 1;
			end
		end
		if ((r << 1) >= n)
			q++;
		if (q > (longint'(1) << OUT_FRAC_BITS))
			q = longint'(1) << OUT_FRAC_BITS;
		return neg ? OUT_WIDTH'(-q) : OUT_WIDTH'(q);
	endfunction

	function automatic elems_t rotation_of(quat_t q);
		longint x, y, z, w, xx, yy, zz, nn;
		elems_t m;
		x = q.quat_x;
		y = q.quat_y;
		z = q.quat_z;
		w = q.quat_w;
		xx = x * x;
		yy = y * y;
		zz = z * z;
		nn = xx + yy + zz + w * w;
		m = '0;
		if (nn == 0) begin
			m.elem_0 = OUT_WIDTH'(1 << OUT_FRAC_BITS);
			m.elem_5 = OUT_WIDTH'(1 << OUT_FRAC_BITS);
			m.elem_10 = OUT_WIDTH'(1 << OUT_FRAC_BITS);
			return m;
		end
		m.elem_0 = scaled_ratio(nn - 2 * (yy + zz), nn);
		m.elem_1 = scaled_ratio(2 * (x * y + w * z), nn);
		m.elem_2 = scaled_ratio(2 * (x * z - w * y), nn);
		m.elem_4 = scaled_ratio(2 * (x * y - w * z), nn);
		m.elem_5 = scaled_ratio(nn - 2 * (xx + zz), nn);
		m.elem_6 = scaled_ratio(2 * (y * z + w * x), nn);
		m.elem_8 = scaled_ratio(2 * (x * z + w * y), nn);
		m.elem_9 = scaled_ratio(2 * (y * z - w * x), nn);
		m.elem_10 = scaled_ratio(nn - 2 * (xx + yy), nn);
		return m;
	endfunction

	function automatic logic [IN_WIDTH-1:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			1: return $urandom_range(0, 1) ? 16'sh1000 : 16'shf000;
			2: return IN_WIDTH'(int'($urandom_range(0, 3)) - 2);
			default: return IN_WIDTH'($urandom);
		endcase
	endfunction

	task automatic push_quat(int x, int y, int z, int w);
		quat_t q;
		q.quat_x = IN_WIDTH'(x);
		q.quat_y = IN_WIDTH'(y);
		q.quat_z = IN_WIDTH'(z);
		q.quat_w = IN_WIDTH'(w);
		pending_quats.push_back(q);
	endtask

	initial begin
		quat_t q;
		// Identity, the zero quaternion, axis turns, extremes and tiny lengths.
		push_quat(0, 0, 0, 0);
		push_quat(0, 0, 0, 4096);
		push_quat(4096, 0, 0, 0);
		push_quat(0, 4096, 0, 0);
		push_quat(0, 0, 4096, 0);
		push_quat(2896, 0, 0, 2896);
		push_quat(0, -2896, 0, 2896);
		push_quat(32767, 32767, 32767, 32767);
		push_quat(-32768, -32768, -32768, -32768);
		push_quat(-32768, 32767, -32768, 32767);
		push_quat(1, 0, 0, 0);
		push_quat(-1, 0, 0, 0);
		push_quat(0, 0, 0, -1);
		push_quat(1, 1, 1, 1);
		push_quat(1, -1, 0, 0);
		push_quat(-32768, 0, 0, 0);
		push_quat(2048, 2048, 2048, 2048);
		push_quat(1, 2, 3, 4);
		push_quat(-3, 5, -7, 11);
		push_quat(32767, 0, 0, 1);
		for (int i = 0; i < 750; i++) begin
			q.quat_x = rand_comp();
			q.quat_y = rand_comp();
			q.quat_z = rand_comp();
			q.quat_w = rand_comp();
			pending_quats.push_back(q);
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			quat <= '0;
		end else begin
			// Record the expected matrix for the transaction accepted at this edge.
			if (start && !busy) begin
				expected_mats.push_back(rotation_of(quat));
				if (pending_quats.size() == 0)
					stim_done = 1;
			end
			// The pause ends once every outstanding result has been checked.
			if (hold_for_drain && expected_mats.size() == 0)
				hold_for_drain = 0;
			if (start && busy) begin
				// Held until accepted.
			end else if (pending_quats.size() == 0) begin
				start <= 1'b0;
			end else if (pending_quats.size() == 400 && !drain_seen) begin
				drain_seen = 1;
				hold_for_drain = 1;
				start <= 1'b0;
			end else if (hold_for_drain && expected_mats.size() != 0) begin
				start <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (!calm && pending_quats.size() < 120) begin
				calm = 1;
				start <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				gap_left = $urandom_range(0, 8);
				start <= 1'b0;
			end else begin
				quat <= pending_quats.pop_front();
				start <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		elems_t exp_m;
		if (arst_n && done) begin
			if (expected_mats.size() == 0) begin
				$display("%0t: unexpected result, actual %h", $realtime, elems);
				errors++;
			end else begin
				exp_m = expected_mats.pop_front();
				if (elems !== exp_m) begin
					$display("%0t: matrix mismatch, expected %h, actual %h",
						$realtime, exp_m, elems);
					errors++;
				end
			end
		end
	end

	initial begin
		wait (stim_done && expected_mats.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire
